// ===== rtl/core/ibusfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibusfr_pkg: shared constants and types of the iBus frame receiver
// Frame geometry, stick mapping limits and the divider request and response.
// ----------------------------------------------------------------------------
package ibusfr_pkg;

  localparam int FRAME_BYTES    = 32;
  localparam int CHANNEL_COUNT  = 14;
  localparam int STICK_CHANNELS = 4;

  localparam int ADDR_W = 5;
  localparam int CH_W   = 4;

  localparam logic [7:0] HDR_BYTE = 8'h20;
  localparam logic [7:0] CMD_BYTE = 8'h40;
  localparam logic [15:0] CHECK_INIT = 16'hFFFF;

  localparam int STICK_CENTER = 1500;
  localparam int STICK_MAX    = 2000;
  localparam int STICK_MIN    = 1000;
  localparam int STICK_FULL   = 100;
  localparam int STICK_SPAN   = STICK_MAX - STICK_CENTER - 1;
  localparam int STICK_SCALE  = STICK_FULL - 1;

  localparam int DEADBAND_W     = 9;
  localparam int DEADBAND_RESET = 20;

  localparam int DIVIDEND_W = 16;
  localparam int DIVISOR_W  = 9;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/ibus_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibus_frame_receiver: iBus frame collector, checker and channel decoder
// Hunts for the header, stores the frame, drops a bad command, checks the
// trailer and emits one transaction per channel (stick-mapped) or one error.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in_       input      in_valid / in_ready       in_byte_in
//  out_      output     out_valid / out_ready     status, channel, raw, stick,
//                                                 last, frame counters
//  cfg_      input      cfg_wr_en                 cfg_wr_data (deadband)
//
//  A byte that does not complete a frame leaves the receiver in ST_IDLE.
//  A completing good frame walks each channel through ST_LO, ST_HI, ST_RAW,
//  ST_MAP and ST_EMIT; a stick channel whose value goes through the shared
//  divider also passes ST_MUL and ST_DIV, which waits for its done pulse.
//  A checksum error is emitted from ST_ERR; output stalls hold it and ST_EMIT.
//  in_ready is low while channel results are produced. Synchronous reset.
// ----------------------------------------------------------------------------
module ibus_frame_receiver
  import ibusfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_status,
  output logic [3:0]                 out_channel_index,
  output logic [15:0]                out_channel_raw,
  output logic signed [7:0]          out_stick_value,
  output logic                       out_is_last,
  output logic [31:0]                out_good_frames,
  output logic [31:0]                out_bad_frames,
  input  wire logic                  cfg_wr_en,
  input  wire logic [DEADBAND_W-1:0] cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LO, ST_HI, ST_RAW, ST_MAP, ST_MUL, ST_DIV, ST_EMIT, ST_ERR
  } state_t;

  state_t                 state_r;
  logic [ADDR_W-1:0]      pos_r;
  logic                   in_frame_r;
  logic                   cmd_ok_r;
  logic [15:0]            check_r;
  logic [7:0]             trail_lo_r;
  logic [31:0]            good_cnt_r;
  logic [31:0]            bad_cnt_r;
  logic [DEADBAND_W-1:0]  deadband_r;
  logic [CH_W-1:0]        ch_r;
  logic [7:0]             lo_r;
  logic [15:0]            raw_r;
  logic [DIVISOR_W-1:0]   x_r;
  logic [DIVISOR_W-1:0]   dvs_r;
  logic                   neg_r;
  logic signed [7:0]      stick_r;

  logic                   out_valid_r;
  logic                   out_status_r;
  logic [3:0]             out_ch_r;
  logic [15:0]            out_raw_r;
  logic signed [7:0]      out_stick_r;
  logic                   out_last_r;
  logic [31:0]            out_good_r;
  logic [31:0]            out_bad_r;

  logic [7:0]             mem [FRAME_BYTES];
  logic [7:0]             rd_data_r;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_wa;
  logic [ADDR_W-1:0]      lo_idx;
  logic [ADDR_W-1:0]      hi_idx;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   lo_ok;
  logic                   hi_ok;
  logic                   in_fire;
  logic                   slot_free;

  logic [16:0]            raw_ext;
  logic [16:0]            d_ext;
  logic [16:0]            hi_thr;
  logic [16:0]            x_hi;
  logic [16:0]            x_lo;
  logic [9:0]             dvs_full;
  logic [7:0]             q_inc;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // channel byte addresses; bytes beyond the frame read as zero
  assign lo_idx  = ADDR_W'({ch_r, 1'b0}) + ADDR_W'(2);
  assign hi_idx  = lo_idx + 1'b1;
  assign lo_ok   = {1'b0, lo_idx} < (ADDR_W + 1)'(FRAME_BYTES);
  assign hi_ok   = {1'b0, hi_idx} < (ADDR_W + 1)'(FRAME_BYTES);
  assign rd_addr = (state_r == ST_LO) ? lo_idx : hi_idx;

  assign mem_we = in_fire && (in_frame_r || in_byte_in == HDR_BYTE);
  assign mem_wa = in_frame_r ? pos_r : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= in_byte_in;
    end
    rd_data_r <= mem[rd_addr];
  end

  // stick classification terms
  always_comb begin
    raw_ext  = {1'b0, raw_r};
    d_ext    = 17'(deadband_r);
    hi_thr   = 17'(STICK_CENTER) + d_ext;
    x_hi     = raw_ext - 17'(STICK_CENTER + 1) - d_ext;
    x_lo     = 17'(STICK_CENTER - 1) - d_ext - raw_ext;
    dvs_full = 10'(STICK_SPAN) - 10'(deadband_r);
    q_inc    = div_rsp.quotient[7:0] + 8'd1;
  end

  assign div_req.start    = (state_r == ST_MUL);
  assign div_req.dividend = 16'(x_r) * 16'(STICK_SCALE);
  assign div_req.divisor  = dvs_r;

  ibusfr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      in_frame_r  <= 1'b0;
      cmd_ok_r    <= 1'b0;
      check_r     <= CHECK_INIT;
      good_cnt_r  <= '0;
      bad_cnt_r   <= '0;
      deadband_r  <= DEADBAND_W'(DEADBAND_RESET);
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        deadband_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (!in_frame_r) begin
              if (in_byte_in == HDR_BYTE) begin
                pos_r      <= ADDR_W'(1);
                in_frame_r <= 1'b1;
                check_r    <= CHECK_INIT - 16'(in_byte_in);
              end
            end else begin
              if ({1'b0, pos_r} < (ADDR_W + 1)'(FRAME_BYTES - 2)) begin
                check_r <= check_r - 16'(in_byte_in);
              end
              if (pos_r == ADDR_W'(1)) begin
                cmd_ok_r <= (in_byte_in == CMD_BYTE);
              end
              if ({1'b0, pos_r} == (ADDR_W + 1)'(FRAME_BYTES - 2)) begin
                trail_lo_r <= in_byte_in;
              end
              if ({1'b0, pos_r} < (ADDR_W + 1)'(FRAME_BYTES - 1)) begin
                pos_r <= pos_r + 1'b1;
              end else begin
                // frame complete: judge it and hunt again
                in_frame_r <= 1'b0;
                pos_r      <= '0;
                if (cmd_ok_r) begin
                  if (check_r == {in_byte_in, trail_lo_r}) begin
                    good_cnt_r <= good_cnt_r + 1'b1;
                    ch_r       <= '0;
                    state_r    <= ST_LO;
                  end else begin
                    bad_cnt_r <= bad_cnt_r + 1'b1;
                    state_r   <= ST_ERR;
                  end
                end
              end
            end
          end
        end

        ST_LO: begin
          state_r <= ST_HI;
        end

        ST_HI: begin
          lo_r    <= lo_ok ? rd_data_r : 8'd0;
          state_r <= ST_RAW;
        end

        ST_RAW: begin
          raw_r   <= {(hi_ok ? rd_data_r : 8'd0), lo_r};
          state_r <= ST_MAP;
        end

        ST_MAP: begin
          state_r <= ST_EMIT;
          dvs_r   <= dvs_full[DIVISOR_W-1:0];
          if (ch_r >= CH_W'(STICK_CHANNELS)) begin
            stick_r <= 8'sd0;
          end else if (raw_ext >= 17'(STICK_MAX)) begin
            stick_r <= 8'(STICK_FULL);
          end else if (raw_ext > hi_thr) begin
            x_r     <= x_hi[DIVISOR_W-1:0];
            neg_r   <= 1'b0;
            state_r <= ST_MUL;
          end else if (raw_ext <= 17'(STICK_MIN)) begin
            stick_r <= -8'(STICK_FULL);
          end else if (raw_ext + d_ext < 17'(STICK_CENTER)) begin
            x_r     <= x_lo[DIVISOR_W-1:0];
            neg_r   <= 1'b1;
            state_r <= ST_MUL;
          end else begin
            stick_r <= 8'sd0;
          end
        end

        ST_MUL: begin
          state_r <= ST_DIV;
        end

        ST_DIV: begin
          if (div_rsp.done) begin
            stick_r <= neg_r ? -q_inc : q_inc;
            state_r <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= 1'b0;
            out_ch_r     <= ch_r;
            out_raw_r    <= raw_r;
            out_stick_r  <= stick_r;
            out_last_r   <= (ch_r == CH_W'(CHANNEL_COUNT - 1));
            out_good_r   <= good_cnt_r;
            out_bad_r    <= bad_cnt_r;
            if (ch_r == CH_W'(CHANNEL_COUNT - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= ST_LO;
            end
          end
        end

        ST_ERR: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= 1'b1;
            out_ch_r     <= '0;
            out_raw_r    <= '0;
            out_stick_r  <= 8'sd0;
            out_last_r   <= 1'b1;
            out_good_r   <= good_cnt_r;
            out_bad_r    <= bad_cnt_r;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_channel_index = out_ch_r;
  assign out_channel_raw   = out_raw_r;
  assign out_stick_value   = out_stick_r;
  assign out_is_last       = out_last_r;
  assign out_good_frames   = out_good_r;
  assign out_bad_frames    = out_bad_r;

`ifndef ASSERT_OFF
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");

  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status && out_is_last |->
      out_channel_index == CH_W'(CHANNEL_COUNT - 1))
    else $error("last flag on a channel other than the final one");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |->
      out_channel_raw == 16'd0 && out_stick_value == 8'sd0 && out_is_last)
    else $error("error transaction carries channel data");

  a_stick_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stick_value <= 8'sd100 && out_stick_value >= -8'sd100)
    else $error("stick value out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ibusfr_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibusfr_divider: restoring divider, one quotient bit per cycle
// Unsigned DIVIDEND_W by DIVISOR_W division; done pulses with the quotient.
// ----------------------------------------------------------------------------
module ibusfr_divider
  import ibusfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    shifted = {rem_r, quo_r[DIVIDEND_W-1]};
    fits    = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        // remainder stays below the divisor, so the low bits carry it
        rem_r <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ===== test/ibus_frame_receiver_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibus_frame_receiver_test: self-checking bench for the iBus frame receiver
// Feeds serial bytes (noise, good frames, checksum and command failures)
// under random back-pressure, decodes every accepted byte in a local model
// of the receiver and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module ibus_frame_receiver_test;
  import ibusfr_pkg::*;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 3;

  localparam logic STATUS_CHANNEL   = 1'b0;
  localparam logic STATUS_CHECK_ERR = 1'b1;

  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_CMD} frame_kind_t;

  typedef struct {
    logic              status;
    logic [3:0]        chan;
    logic [15:0]       raw;
    logic signed [7:0] stick;
    logic              last;
    logic [31:0]       good;
    logic [31:0]       bad;
  } chan_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_byte_in = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_status;
  logic [3:0]            out_channel_index;
  logic [15:0]           out_channel_raw;
  logic signed [7:0]     out_stick_value;
  logic                  out_is_last;
  logic [31:0]           out_good_frames;
  logic [31:0]           out_bad_frames;
  logic                  cfg_wr_en = 1'b0;
  logic [DEADBAND_W-1:0] cfg_wr_data = '0;

  // bench control
  logic [7:0]   serial_bytes [$];
  chan_result_t channel_results_due [$];
  logic [15:0]  chan_plan [CHANNEL_COUNT];
  logic         calm = 1'b0;
  int           in_gap = 0;
  int           out_stall = 0;
  int           quiet_cycles = 0;
  int           mismatch_count = 0;

  // receiver model state
  logic [7:0]            frm [FRAME_BYTES];
  logic [ADDR_W-1:0]     frm_pos = '0;
  logic                  frm_open = 1'b0;
  logic [15:0]           frm_check = CHECK_INIT;
  logic [31:0]           good_cnt = '0;
  logic [31:0]           bad_cnt = '0;
  logic [DEADBAND_W-1:0] dband = DEADBAND_W'(DEADBAND_RESET);

  ibus_frame_receiver u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_channel_index (out_channel_index),
    .out_channel_raw   (out_channel_raw),
    .out_stick_value   (out_stick_value),
    .out_is_last       (out_is_last),
    .out_good_frames   (out_good_frames),
    .out_bad_frames    (out_bad_frames),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic logic signed [7:0] map_stick(logic [15:0] raw, logic [DEADBAND_W-1:0] db);
    int r;
    int d;
    int v;
    r = raw;
    d = db;
    if (r >= STICK_MAX) begin
      v = STICK_FULL;
    end else if (r > STICK_CENTER + d) begin
      v = 1 + (STICK_SCALE * (r - STICK_CENTER - 1 - d)) / (STICK_SPAN - d);
    end else if (r <= STICK_MIN) begin
      v = -STICK_FULL;
    end else if (r < STICK_CENTER - d) begin
      v = -1 - (STICK_SCALE * (STICK_CENTER - 1 - d - r)) / (STICK_SPAN - d);
    end else begin
      v = 0;
    end
    return 8'(v);
  endfunction

  // Advance the receiver model by one byte and queue the results it causes.
  task automatic decode_byte(input logic [7:0] b);
    chan_result_t      res;
    logic [15:0]       trailer;
    logic [ADDR_W-1:0] p;
    int                i;
    if (!frm_open) begin
      if (b == HDR_BYTE) begin
        frm[0] = b;
        frm_pos = ADDR_W'(1);
        frm_open = 1'b1;
        frm_check = CHECK_INIT - b;
      end
    end else begin
      p = frm_pos;
      frm[p] = b;
      if (p < FRAME_BYTES - 2) frm_check = frm_check - b;
      if (p + 1 < FRAME_BYTES) begin
        frm_pos = p + 1'b1;
      end else begin
        frm_open = 1'b0;
        frm_pos = '0;
        if (frm[1] == CMD_BYTE) begin
          trailer = {frm[FRAME_BYTES-1], frm[FRAME_BYTES-2]};
          if (frm_check != trailer) begin
            bad_cnt = bad_cnt + 1;
            res.status = STATUS_CHECK_ERR;
            res.chan = '0;
            res.raw = '0;
            res.stick = '0;
            res.last = 1'b1;
            res.good = good_cnt;
            res.bad = bad_cnt;
            channel_results_due.push_back(res);
          end else begin
            good_cnt = good_cnt + 1;
            for (i = 0; i < CHANNEL_COUNT; i++) begin
              res.status = STATUS_CHANNEL;
              res.chan = 4'(i);
              res.raw = {frm[3+2*i], frm[2+2*i]};
              res.stick = (i < STICK_CHANNELS) ? map_stick(res.raw, dband) : 8'sd0;
              res.last = (i == CHANNEL_COUNT - 1);
              res.good = good_cnt;
              res.bad = bad_cnt;
              channel_results_due.push_back(res);
            end
          end
        end
      end
    end
  endtask

  task automatic note_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) note_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Queue one frame built from chan_plan; the trailer follows the kind.
  task automatic queue_frame(input frame_kind_t kind);
    logic [7:0]  fr [FRAME_BYTES];
    logic [15:0] sum;
    logic [15:0] trl;
    int          k;
    fr[0] = HDR_BYTE;
    fr[1] = CMD_BYTE;
    if (kind == FRAME_BAD_CMD) begin
      fr[1] = 8'($urandom_range(0, 255));
      if (fr[1] == CMD_BYTE) fr[1] = ~CMD_BYTE;
    end
    for (k = 0; k < CHANNEL_COUNT; k++) begin
      fr[2+2*k] = chan_plan[k][7:0];
      fr[3+2*k] = chan_plan[k][15:8];
    end
    sum = '0;
    for (k = 0; k < FRAME_BYTES - 2; k++) sum = sum + fr[k];
    trl = CHECK_INIT - sum;
    if (kind == FRAME_BAD_SUM) trl = trl ^ 16'($urandom_range(1, 65535));
    fr[FRAME_BYTES-2] = trl[7:0];
    fr[FRAME_BYTES-1] = trl[15:8];
    for (k = 0; k < FRAME_BYTES; k++) serial_bytes.push_back(fr[k]);
  endtask

  // Line noise while hunting; now and then a stray header breaks alignment.
  task automatic queue_noise(input int n);
    logic [7:0] b;
    int         k;
    for (k = 0; k < n; k++) begin
      b = 8'($urandom_range(0, 255));
      if (b == HDR_BYTE) b = b ^ 8'h01;
      if ($urandom_range(0, 11) == 0) b = HDR_BYTE;
      serial_bytes.push_back(b);
    end
  endtask

  function automatic logic [15:0] pick_stick(int d);
    case ($urandom_range(0, 11))
      0:       return 16'(STICK_MIN);
      1:       return 16'(STICK_MIN + 1);
      2:       return 16'(STICK_CENTER - 1 - d);
      3:       return 16'(STICK_CENTER - d);
      4:       return 16'(STICK_CENTER);
      5:       return 16'(STICK_CENTER + d);
      6:       return 16'(STICK_CENTER + 1 + d);
      7:       return 16'(STICK_MAX - 1);
      8:       return 16'(STICK_MAX);
      9:       return 16'($urandom_range(900, 2100));
      10:      return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(STICK_MIN, STICK_MAX));
    endcase
  endfunction

  task automatic plan_random_channels();
    int k;
    for (k = 0; k < CHANNEL_COUNT; k++) begin
      if (k < STICK_CHANNELS) chan_plan[k] = pick_stick(dband);
      else if ($urandom_range(0, 7) == 0) chan_plan[k] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else chan_plan[k] = 16'($urandom_range(0, 65535));
    end
  endtask

  task automatic queue_random_frame();
    int r;
    plan_random_channels();
    queue_noise($urandom_range(0, 4));
    r = $urandom_range(0, 9);
    if (r < 7) queue_frame(FRAME_GOOD);
    else if (r < 9) queue_frame(FRAME_BAD_SUM);
    else queue_frame(FRAME_BAD_CMD);
  endtask

  // Hold until the sender is drained and every result has come, then settle.
  task automatic wait_idle();
    while (serial_bytes.size() != 0 || in_valid || channel_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_deadband(input logic [DEADBAND_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dband = v;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte_in);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (serial_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte_in <= serial_bytes.pop_front();
          if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    chan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (channel_results_due.size() == 0) begin
        note_error($sformatf("unexpected result on channel %0d", out_channel_index));
      end else begin
        want = channel_results_due.pop_front();
        check_field("status", out_status, want.status);
        check_field("channel_index", out_channel_index, want.chan);
        check_field("channel_raw", out_channel_raw, want.raw);
        check_field("stick_value", out_stick_value, want.stick);
        check_field("is_last", out_is_last, want.last);
        check_field("good_frames", out_good_frames, want.good);
        check_field("bad_frames", out_bad_frames, want.bad);
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: drop the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [DEADBAND_W-1:0] phase_db [PHASES];
    int ph;
    int k;
    phase_db[0] = '0;
    phase_db[1] = 9'd499;
    phase_db[2] = 9'($urandom_range(0, 400));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: noise, extremes with a header byte inside the data, a deadband
    // edge frame, then a checksum failure and a silently dropped bad command byte
    serial_bytes.push_back(8'h00);
    serial_bytes.push_back(8'hFF);
    serial_bytes.push_back(CMD_BYTE);
    chan_plan[0] = 16'h0000;
    chan_plan[1] = 16'(STICK_MIN);
    chan_plan[2] = 16'hFFFF;
    chan_plan[3] = 16'(STICK_MAX);
    for (k = STICK_CHANNELS; k < CHANNEL_COUNT; k++)
      chan_plan[k] = (k % 3 == 0) ? 16'h2020 : ((k % 3 == 1) ? 16'hFFFF : 16'h0000);
    queue_frame(FRAME_GOOD);
    chan_plan[0] = 16'(STICK_CENTER - DEADBAND_RESET - 1);
    chan_plan[1] = 16'(STICK_CENTER - DEADBAND_RESET);
    chan_plan[2] = 16'(STICK_CENTER + DEADBAND_RESET);
    chan_plan[3] = 16'(STICK_CENTER + DEADBAND_RESET + 1);
    queue_frame(FRAME_GOOD);
    queue_frame(FRAME_BAD_SUM);
    queue_frame(FRAME_BAD_CMD);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES - 1) calm = 1'b1;
      write_deadband(phase_db[ph]);
      queue_random_frame();
    end

    wait_idle();
    if (channel_results_due.size() != 0) note_error("results still expected at end of run");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ibusfr_pkg.sv
rtl/core/ibusfr_divider.sv
rtl/core/ibus_frame_receiver.sv
test/ibus_frame_receiver_test.sv
